[rtl/pwq_pkg.sv]
// Package for the playback window quality block: sizes, shared types and
// sequence helpers. Depends on nothing; every other file imports it.
package pwq_pkg;

  localparam int WINDOW      = 256;
  localparam int QUEUE_DEPTH = 512;
  localparam int SEQ_W       = 32;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SPAN_W      = $clog2(WINDOW + 2);
  localparam int FRAC_W      = 16;
  localparam int QUAL_W      = FRAC_W + 1;
  localparam int OUT_W       = 9;
  localparam int OUT_MAX     = (1 << OUT_W) - 1;
  localparam int STEP_W      = $clog2(FRAC_W + 1);

  localparam logic [QUAL_W-1:0] FULL_QUALITY = QUAL_W'(1 << FRAC_W);

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DRAG,
    ST_POP_RD,
    ST_POP_CHK,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic             clear;
    logic             push;
    logic             pop;
    logic             rd;
    logic [SEQ_W-1:0] data;
  } queue_cmd_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic [SEQ_W-1:0]  rd_data;
  } queue_stat_t;

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quo;
  } div_stat_t;

  // True when a lies before b by signed difference of the wrapping numbers.
  function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                      input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return d[SEQ_W-1];
  endfunction

endpackage

[rtl/pwq_if.sv]
// Valid/ready channels for the item and result beats of the block.
// Depends on pwq_pkg.
interface pwq_item_if;
  import pwq_pkg::*;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [SEQ_W-1:0] seq;
  logic             good;
  modport source(output valid, opcode, seq, good, input ready);
  modport sink(input valid, opcode, seq, good, output ready);
endinterface

interface pwq_result_if;
  import pwq_pkg::*;
  logic              valid;
  logic              ready;
  logic [QUAL_W-1:0] quality;
  logic [OUT_W-1:0]  good_count;
  logic [OUT_W-1:0]  window_span;
  modport source(output valid, quality, good_count, window_span, input ready);
  modport sink(input valid, quality, good_count, window_span, output ready);
endinterface

[rtl/pwq_queue.sv]
// Circular FIFO of good sequence numbers with a registered read of the front.
// Depends on pwq_pkg.
module pwq_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  pwq_pkg::queue_cmd_t  cmd,
  output pwq_pkg::queue_stat_t stat
);
  import pwq_pkg::*;

  logic [SEQ_W-1:0]   mem [QUEUE_DEPTH];
  logic [QADDR_W-1:0] head;
  logic [QCNT_W-1:0]  count;
  logic [SEQ_W-1:0]   rd_data;
  logic [QADDR_W:0]   tail_sum;
  logic [QADDR_W-1:0] tail;
  logic [QADDR_W-1:0] head_next;
  logic               full;

  assign full = (32'(count) == 32'(QUEUE_DEPTH));

  always_comb begin
    tail_sum = (QADDR_W+1)'(head) + (QADDR_W+1)'(count);
    if (32'(tail_sum) >= 32'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QADDR_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QADDR_W-1:0];
    if (32'(head) == 32'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + QADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.clear) begin
      head  <= '0;
      count <= '0;
    end else if (cmd.push && !full) begin
      count <= count + QCNT_W'(1);
    end else if (cmd.pop && count != '0) begin
      head  <= head_next;
      count <= count - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !full && !cmd.clear) begin
      mem[tail] <= cmd.data;
    end
    if (cmd.rd) begin
      rd_data <= mem[head];
    end
  end

  assign stat.count   = count;
  assign stat.full    = full;
  assign stat.rd_data = rd_data;

endmodule

[rtl/pwq_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle of a count
// shifted up by the fraction width over a smaller span. Depends on pwq_pkg.
module pwq_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pwq_pkg::SPAN_W-1:0]  dividend,
  input  logic [pwq_pkg::SPAN_W-1:0]  divisor,
  output pwq_pkg::div_stat_t          stat
);
  import pwq_pkg::*;

  logic [SPAN_W:0]   rem;
  logic [SPAN_W-1:0] dvs;
  logic [FRAC_W-1:0] quo;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [SPAN_W+1:0] trial;

  // The remainder stays below the divisor, so twice it fits one extra bit.
  assign trial = {rem, 1'b0} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (32'(step) == 32'(FRAC_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= {1'b0, dividend};
      dvs <= divisor;
      quo <= '0;
    end else if (busy) begin
      if (!trial[SPAN_W+1]) begin
        rem <= trial[SPAN_W:0];
        quo <= {quo[FRAC_W-2:0], 1'b1};
      end else begin
        rem <= {rem[SPAN_W-1:0], 1'b0};
        quo <= {quo[FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign stat.done = done;
  assign stat.quo  = quo;

endmodule

[rtl/playback_window_quality.sv]
// A push beat passes the update, drag, pop read and pop check steps, then the divide
// start and divide wait steps, where the bit-serial divide makes 16 quotient bits
// and then signals done. Each stale entry popped from the front of the queue adds
// one more pop read and pop check (one registered read and one compare on its single
// read port). The divide is skipped when the queue is empty or holds at least a full
// span, and the beat goes from divide start to the last step. A clear beat goes from
// the update step straight to the last step. One beat is worked on at a time; a finished
// result waits in the output register while the next beat is taken, and a result that
// is not taken holds the block in its last step.
module playback_window_quality (
  input  logic         clk,
  input  logic         rst,
  pwq_item_if.sink     items,
  pwq_result_if.source results
);
  import pwq_pkg::*;

  state_t state, state_next;

  logic              op_r;
  logic [SEQ_W-1:0]  seq_r;
  logic              good_r;
  logic              newest_valid;
  logic [SEQ_W-1:0]  newest_seq;
  logic              start_valid;
  logic [SEQ_W-1:0]  start_seq;
  logic [SPAN_W-1:0] span_r;
  logic [QUAL_W-1:0] qual_r;
  logic [SEQ_W-1:0]  lag;
  logic              out_free;
  logic              div_start;

  queue_cmd_t  q_cmd;
  queue_stat_t q_stat;
  div_stat_t   d_stat;

  pwq_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .cmd  (q_cmd),
    .stat (q_stat)
  );

  pwq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (SPAN_W'(q_stat.count)),
    .divisor  (span_r),
    .stat     (d_stat)
  );

  assign lag      = newest_seq - start_seq;
  assign out_free = !results.valid || results.ready;
  assign items.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_cmd      = '0;
    q_cmd.data = seq_r;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        if (op_r == OP_CLEAR) begin
          q_cmd.clear = 1'b1;
          state_next  = ST_FIN;
        end else begin
          state_next = ST_DRAG;
        end
      end
      ST_DRAG: begin
        q_cmd.push = good_r;
        state_next = ST_POP_RD;
      end
      ST_POP_RD: begin
        if (q_stat.count == '0) begin
          state_next = ST_DIV_GO;
        end else begin
          q_cmd.rd   = 1'b1;
          state_next = ST_POP_CHK;
        end
      end
      ST_POP_CHK: begin
        if (seq_before(q_stat.rd_data, start_seq)) begin
          q_cmd.pop  = 1'b1;
          state_next = ST_POP_RD;
        end else begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        if (q_stat.count == '0 || 32'(q_stat.count) >= 32'(span_r)) begin
          state_next = ST_FIN;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (d_stat.done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Captured beat; payload only.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && items.valid) begin
      op_r   <= items.opcode;
      seq_r  <= items.seq;
      good_r <= items.good;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_valid <= 1'b0;
      newest_seq   <= '0;
      start_valid  <= 1'b0;
      start_seq    <= '0;
    end else if (state == ST_UPD) begin
      if (op_r == OP_CLEAR) begin
        newest_valid <= 1'b0;
        newest_seq   <= '0;
        start_valid  <= 1'b0;
        start_seq    <= '0;
      end else begin
        if (!newest_valid || seq_before(newest_seq, seq_r)) begin
          newest_seq   <= seq_r;
          newest_valid <= 1'b1;
        end
        if (!start_valid) begin
          start_seq   <= seq_r;
          start_valid <= 1'b1;
        end
      end
    end else if (state == ST_DRAG) begin
      if (lag > SEQ_W'(WINDOW)) begin
        start_seq <= newest_seq - SEQ_W'(WINDOW);
      end
    end
  end

  // The span is fixed once the window has been dragged.
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      span_r <= '0;
    end else if (state == ST_DRAG) begin
      if (lag > SEQ_W'(WINDOW)) begin
        span_r <= SPAN_W'(WINDOW + 1);
      end else begin
        span_r <= lag[SPAN_W-1:0] + SPAN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      qual_r <= '0;
    end else if (state == ST_DIV_GO) begin
      if (q_stat.count == '0) begin
        qual_r <= '0;
      end else begin
        qual_r <= FULL_QUALITY;
      end
    end else if (state == ST_DIV_WAIT && d_stat.done) begin
      qual_r <= {1'b0, d_stat.quo};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      results.quality <= qual_r;
      if (32'(q_stat.count) > 32'(OUT_MAX)) begin
        results.good_count <= OUT_W'(OUT_MAX);
      end else begin
        results.good_count <= OUT_W'(q_stat.count);
      end
      if (32'(span_r) > 32'(OUT_MAX)) begin
        results.window_span <= OUT_W'(OUT_MAX);
      end else begin
        results.window_span <= OUT_W'(span_r);
      end
    end
  end

  // Once dragged, the window never spans more than WINDOW + 1 numbers.
  a_window_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_POP_RD || state == ST_POP_CHK) |-> lag <= SEQ_W'(WINDOW))
    else $error("window start lags newest by more than the window");

  a_markers_paired: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (newest_valid == start_valid))
    else $error("newest and start markers disagree on validity");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    32'(q_stat.count) <= 32'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_quality_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN) |-> (qual_r <= FULL_QUALITY))
    else $error("quality above full scale");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state_next == ST_DIV_WAIT) && (span_r != '0))
    else $error("divide started without a span");

endmodule
